/* rtl/smbse_pkg.sv */
`timescale 1ns / 1ps

package smbse_pkg;

  // Request codes carried on the request type field.
  typedef enum logic [2:0] {
    REQ_PUSH = 3'd0,
    REQ_POP  = 3'd1,
    REQ_PEEK = 3'd2,
    REQ_POKE = 3'd3,
    REQ_SWAP = 3'd4
  } req_e;

  // Completion codes returned with every response.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BADADDR   = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_BADSWAP   = 3'd4
  } status_e;

  // Sequencer states. The swap walks four in-place reversals, one word pair at a time.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SEG,
    S_RDI,
    S_RDJ,
    S_WRI,
    S_WRJ
  } state_e;

endpackage

/* rtl/stack_memory_block_swap_engine.sv */
`timescale 1ns / 1ps

// Bounded word stack held in a synchronous single-read, single-write memory.
// Requests arrive on the req channel (valid/ready) and each one produces exactly
// one response on the rsp channel (valid/ready): a status and, for pop and peek,
// the word read. The stack_size register is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle, as the block itself does
// not enforce this. It bounds push together with STACK_DEPTH. Push, poke, rejected
// requests and unknown codes are answered from the decode state; pop and peek
// pass from the decode state through the registered memory read to a read state
// that raises the response. A successful block swap rewrites its span by four
// reversals (whole span, then each of its three parts); each word pair is read
// lower word first, then upper, and written back with the two words exchanged;
// the sequencer then steps to the next pair, or to the next part when none is left.
// Only one request is in flight. A new request is taken when the sequencer is
// idle and the response register is empty or being emptied in the same cycle,
// so a stalled receiver holds the response and backs the request side up.
// Reset clears the depth pointer, returns stack_size to 1024 and empties the
// response register. The memory contents are not cleared: no word above the
// depth is ever read, so none is needed.
module stack_memory_block_swap_engine
  import smbse_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int WORD_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [9:0]  first_addr_i,
  input  logic [10:0] first_size_i,
  input  logic [9:0]  second_addr_i,
  input  logic [10:0] second_size_i,
  input  logic [31:0] write_value_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] read_value_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (DW > 11) ? DW : 11;
  localparam int XW = CW + 1;
  localparam int RB = (WORD_BITS < 32) ? WORD_BITS : 32;

  state_e state_q, state_d;

  logic [DW-1:0] sp_q, sp_d;
  logic [10:0]   size_q;

  // Captured request.
  logic [2:0]  type_q;
  logic [9:0]  a1_q, a2_q;
  logic [10:0] s1_q, s2_q;
  logic [31:0] wv_q;

  // Response register.
  logic        rsp_valid_q, rsp_valid_d;
  status_e     status_q, status_d;
  logic [31:0] rdv_q, rdv_d;

  // Swap walker: segment number, pair pointers and segment boundaries.
  logic [1:0]    seg_q, seg_d;
  logic [CW-1:0] i_q, i_d, e_q, e_d;
  logic [CW-1:0] lo_q, lo_d, b1_q, b1_d, b2_q, b2_d, end_q, end_d;
  logic [WORD_BITS-1:0] di_q;

  // Memory and its ports.
  logic [WORD_BITS-1:0] mem [STACK_DEPTH];
  logic [WORD_BITS-1:0] rdata_q, mem_wdata;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic                 mem_we, mem_re;

  // Decode terms.
  logic [XW-1:0] spx, a1x, a2x, s1x, s2x, bound, lox, lszx, hix, hszx, endx;
  logic          push_ok, addr_ok, oob, overlap, first_low, pair_left, req_fire;
  logic [DW-1:0] sp_m1;
  logic [CW-1:0] jaddr;

  assign req_fire    = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready_i);
  assign rsp_valid_o = rsp_valid_q;
  assign status_o    = status_q;
  assign read_value_o = rdv_q;

  always_comb begin
    spx   = XW'(sp_q);
    a1x   = XW'(a1_q);
    a2x   = XW'(a2_q);
    s1x   = XW'(s1_q);
    s2x   = XW'(s2_q);
    bound = (XW'(size_q) > XW'(STACK_DEPTH)) ? XW'(STACK_DEPTH) : XW'(size_q);
    push_ok = spx < bound;
    addr_ok = a1x < spx;
    oob     = (s1x > spx) || (s2x > spx) || (a1x + s1x > spx) || (a2x + s2x > spx);
    // The second block is the lower one when both starts are equal.
    first_low = a1_q < a2_q;
    lox     = first_low ? a1x : a2x;
    lszx    = first_low ? s1x : s2x;
    hix     = first_low ? a2x : a1x;
    hszx    = first_low ? s2x : s1x;
    overlap = (lox + lszx) > hix;
    endx    = hix + hszx;
    sp_m1   = sp_q - DW'(1);
    jaddr   = e_q - CW'(1);
    pair_left = (i_q + CW'(1)) < e_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (req_fire) state_d = S_DECODE;
      S_DECODE: begin
        state_d = S_IDLE;
        case (type_q)
          REQ_POP:  if (sp_q != '0) state_d = S_READ;
          REQ_PEEK: if (addr_ok) state_d = S_READ;
          REQ_SWAP: if (!oob && !overlap) state_d = S_SEG;
          default:  state_d = S_IDLE;
        endcase
      end
      S_READ:   state_d = S_IDLE;
      S_SEG: begin
        if (pair_left) begin
          state_d = S_RDI;
        end else if (seg_q == 2'd3) begin
          state_d = S_IDLE;
        end
      end
      S_RDI:    state_d = S_RDJ;
      S_RDJ:    state_d = S_WRI;
      S_WRI:    state_d = S_WRJ;
      S_WRJ:    state_d = S_SEG;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and memory port control.
  always_comb begin
    sp_d        = sp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    status_d    = status_q;
    rdv_d       = rdv_q;
    seg_d       = seg_q;
    i_d         = i_q;
    e_d         = e_q;
    lo_d        = lo_q;
    b1_d        = b1_q;
    b2_d        = b2_q;
    end_d       = end_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = i_q[AW-1:0];
    mem_raddr   = i_q[AW-1:0];
    mem_wdata   = WORD_BITS'(wv_q[RB-1:0]);
    case (state_q)
      S_DECODE: begin
        rsp_valid_d = 1'b1;
        status_d    = ST_OK;
        rdv_d       = '0;
        case (type_q)
          REQ_PUSH: begin
            if (push_ok) begin
              mem_we    = 1'b1;
              mem_waddr = sp_q[AW-1:0];
              sp_d      = sp_q + DW'(1);
            end else begin
              status_d = ST_OVERFLOW;
            end
          end
          REQ_POP: begin
            if (sp_q != '0) begin
              // The response is raised in the read cycle that follows.
              rsp_valid_d = 1'b0;
              mem_re      = 1'b1;
              mem_raddr   = sp_m1[AW-1:0];
              sp_d        = sp_m1;
            end else begin
              status_d = ST_UNDERFLOW;
            end
          end
          REQ_PEEK: begin
            if (addr_ok) begin
              rsp_valid_d = 1'b0;
              mem_re      = 1'b1;
              mem_raddr   = AW'(a1x);
            end else begin
              status_d = ST_BADADDR;
            end
          end
          REQ_POKE: begin
            if (addr_ok) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(a1x);
            end else begin
              status_d = ST_BADADDR;
            end
          end
          REQ_SWAP: begin
            if (oob) begin
              status_d = ST_OVERFLOW;
            end else if (overlap) begin
              status_d = ST_BADSWAP;
            end else begin
              // Reversing the whole span, then the upper, middle and lower parts
              // in their new places, yields upper block, middle, lower block.
              rsp_valid_d = 1'b0;
              seg_d = 2'd0;
              lo_d  = CW'(lox);
              b1_d  = CW'(lox + hszx);
              b2_d  = CW'(endx - lszx);
              end_d = CW'(endx);
              i_d   = CW'(lox);
              e_d   = CW'(endx);
            end
          end
          default: status_d = ST_BADADDR;
        endcase
      end
      S_READ: begin
        rsp_valid_d = 1'b1;
        status_d    = ST_OK;
        rdv_d       = 32'(rdata_q[RB-1:0]);
      end
      S_SEG: begin
        if (!pair_left) begin
          seg_d = seg_q + 2'd1;
          case (seg_q)
            2'd0: begin
              i_d = lo_q;
              e_d = b1_q;
            end
            2'd1: begin
              i_d = b1_q;
              e_d = b2_q;
            end
            2'd2: begin
              i_d = b2_q;
              e_d = end_q;
            end
            default: begin
              rsp_valid_d = 1'b1;
              status_d    = ST_OK;
              rdv_d       = '0;
            end
          endcase
        end
      end
      S_RDI: begin
        mem_re    = 1'b1;
        mem_raddr = i_q[AW-1:0];
      end
      S_RDJ: begin
        mem_re    = 1'b1;
        mem_raddr = jaddr[AW-1:0];
      end
      S_WRI: begin
        mem_we    = 1'b1;
        mem_waddr = i_q[AW-1:0];
        mem_wdata = rdata_q;
      end
      S_WRJ: begin
        mem_we    = 1'b1;
        mem_waddr = jaddr[AW-1:0];
        mem_wdata = di_q;
        i_d       = i_q + CW'(1);
        e_d       = e_q - CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      size_q      <= 11'd1024;
      rsp_valid_q <= 1'b0;
      seg_q       <= '0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      rsp_valid_q <= rsp_valid_d;
      seg_q       <= seg_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      type_q <= req_type_i;
      a1_q   <= first_addr_i;
      s1_q   <= first_size_i;
      a2_q   <= second_addr_i;
      s2_q   <= second_size_i;
      wv_q   <= write_value_i;
    end
    status_q <= status_d;
    rdv_q    <= rdv_d;
    i_q      <= i_d;
    e_q      <= e_d;
    lo_q     <= lo_d;
    b1_q     <= b1_d;
    b2_q     <= b2_d;
    end_q    <= end_d;
    // The lower word of a pair is held while the upper one is fetched.
    if (state_q == S_RDJ) begin
      di_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

endmodule
